@@ hdl/rprb_pkg.sv @@
// Package for the ramp pattern ring buffer: field widths, action codes and
// the control bundle passed from the sequencer to the datapath.
// No dependencies.
package rprb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int LEN_W    = 9;
    localparam int ACT_W    = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

    localparam logic [ACT_W-1:0] ACT_FILL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RAMP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic busy;      // not taking a request
        logic clearing;  // reset sweep writes zero
        logic load_run;  // fill or ramp request with nonzero count taken
        logic writing;   // one run entry written this cycle
        logic reading;   // read data valid at the store output
    } seq_ctl_t;

endpackage

@@ hdl/rprb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rprb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/rprb_seq.sv @@
// Sequencer for the ramp pattern ring buffer: reset sweep, run counter and
// read slot. Depends on rprb_pkg.
module rprb_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rprb_pkg::ACT_W-1:0]   action,
    input  logic [rprb_pkg::COUNT_W-1:0] count,
    input  logic                         sweep_last,
    output rprb_pkg::seq_ctl_t           ctl
);

    import rprb_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic               take;
    logic               is_run;

    assign take   = start && (state_reg == S_IDLE);
    assign is_run = (action == ACT_FILL) || (action == ACT_RAMP);

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take && is_run && (count != '0))
                begin
                    state_next  = S_WRITE;
                    remain_next = count;
                end
                else if (take && (action == ACT_READ))
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                remain_next = remain_reg - COUNT_W'(1);
                if (remain_reg == COUNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    assign ctl.busy     = (state_reg != S_IDLE);
    assign ctl.clearing = (state_reg == S_CLEAR);
    assign ctl.load_run = take && is_run && (count != '0);
    assign ctl.writing  = (state_reg == S_WRITE);
    assign ctl.reading  = (state_reg == S_READ);

endmodule

@@ hdl/ramp_pattern_ring_buffer_unit.sv @@
// Top level of the ramp pattern ring buffer: pointers, run value adder and
// output register around the sample store. Depends on rprb_pkg, rprb_ram, rprb_seq.
//
//   channel   | signals                                    | handshake
//   ----------+--------------------------------------------+----------------------
//   request   | action, start_value, step_value, count     | start high, busy low
//   result    | sample                                     | done, one cycle
//   config    | seq_length                                 | seq_length_wr
//
// After reset the store is swept to zero, one entry a cycle, through every address;
// busy stays high meanwhile (seq_length writes are still taken).
// On a read request the store is read in the cycle after it is taken,
// and sample/done follow in the next, when busy is already low again.
// A fill or ramp request writes count entries through the store write port;
// a zero count, or the unused action code, writes nothing and leaves busy low.
// done cannot be held off: high for one cycle; sample holds until the next read.
module ramp_pattern_ring_buffer_unit #(
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rprb_pkg::ACT_W-1:0]    action,
    input  logic signed [rprb_pkg::SAMPLE_W-1:0] start_value,
    input  logic signed [rprb_pkg::SAMPLE_W-1:0] step_value,
    input  logic [rprb_pkg::COUNT_W-1:0]  count,
    input  logic                          seq_length_wr,
    input  logic [rprb_pkg::LEN_W-1:0]    seq_length,
    output logic                          done,
    output logic signed [rprb_pkg::SAMPLE_W-1:0] sample
);

    import rprb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(DEPTH - 1);

    seq_ctl_t          ctl;
    logic [LEN_W-1:0]  len_reg;
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    sample_t           val_reg, val_next;
    sample_t           step_reg, step_next;
    sample_t           sample_reg;
    logic              done_reg;
    logic [PTR_W-1:0]  last_idx;
    logic [31:0]       len_ext;
    logic              sweep_last;
    sample_t           rdata;
    sample_t           wdata;
    logic              we;

    // Clamp the ring length into 1..DEPTH and form the wrap index.
    assign len_ext = 32'(len_reg);

    always_comb
    begin
        priority if (len_ext == 32'd0)
        begin
            last_idx = '0;
        end
        else if (len_ext > 32'(DEPTH))
        begin
            last_idx = LAST_ADDR;
        end
        else
        begin
            last_idx = PTR_W'(len_ext - 32'd1);
        end
    end

    // Advance a pointer, or drop it back to the start at (or past) the wrap index.
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                 input logic [PTR_W-1:0] last);
        advance = (ptr < last) ? (ptr + PTR_W'(1)) : '0;
    endfunction

    assign sweep_last = ctl.clearing && (wptr_reg == LAST_ADDR);

    rprb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .count      (count),
        .sweep_last (sweep_last),
        .ctl        (ctl)
    );

    // The write pointer doubles as the sweep address during the reset clear.
    assign we    = ctl.clearing || ctl.writing;
    assign wdata = ctl.clearing ? '0 : val_reg;

    rprb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wptr_reg),
        .wdata (wdata),
        .raddr (rptr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        val_next  = val_reg;
        step_next = step_reg;
        if (ctl.clearing)
        begin
            wptr_next = sweep_last ? '0 : (wptr_reg + PTR_W'(1));
        end
        if (ctl.load_run)
        begin
            // Hold the run value and step; a fill simply steps by zero.
            val_next  = sample_t'(start_value);
            step_next = (action == ACT_RAMP) ? sample_t'(step_value) : '0;
        end
        if (ctl.writing)
        begin
            wptr_next = advance(wptr_reg, last_idx);
            val_next  = val_reg + step_reg;
        end
        if (ctl.reading)
        begin
            rptr_next = advance(rptr_reg, last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            wptr_reg <= '0;
            rptr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (seq_length_wr)
            begin
                len_reg <= seq_length;
            end
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            done_reg <= ctl.reading;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        step_reg <= step_next;
        if (ctl.reading)
        begin
            sample_reg <= rdata;
        end
    end

    assign busy   = ctl.busy;
    assign done   = done_reg;
    assign sample = sample_reg;

    // The sequencer never does more than one of clear, write and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clearing, ctl.writing, ctl.reading}))
        else $error("store clear, run write and read overlap");

    // A taken read request is followed by done, via the read slot and the done register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_READ)) |=> ##1 done)
        else $error("read request gave no result");

    // A result only follows the read slot, and the block is free by then.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(ctl.reading))
        else $error("result strobe without a read");

    // No run entry is written outside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.writing |-> (wptr_reg <= LAST_ADDR))
        else $error("write pointer outside the store");

endmodule
